// ===== design/crc16_pkg.sv =====
// Shared types, constants and the byte fold function of the CRC-16 stream block.
package crc16_pkg;

   localparam logic [15:0] CRC_POLY        = 16'h1021;
   localparam logic [15:0] CRC_RESET_START = 16'h1021;
   localparam int          BYTE_BITS       = 8;

   typedef struct packed {
      logic [15:0] data_word;
      logic        byte_mode;
      logic        first_item;
      logic        last_item;
   } req_item_type;

   typedef struct packed {
      logic [15:0] crc_value;
      logic        is_final;
   } rsp_item_type;

   // Input stage contents as seen by the fold and output stages.
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   // MSB-first fold of one byte into the remainder, eight shift/xor steps.
   function automatic logic [15:0] fold_byte(input logic [15:0] rem, input logic [7:0] data);
      logic [15:0] r;
      r = rem ^ {data, 8'h00};
      for (int i = 0; i < BYTE_BITS; i++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ===== design/crc16_req_if.sv =====
// Request channel interface: valid/ready handshake with one message element.
interface crc16_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_word;
   logic        byte_mode;
   logic        first_item;
   logic        last_item;

   modport source (output valid, output data_word, output byte_mode, output first_item,
                   output last_item, input ready);
   modport sink   (input valid, input data_word, input byte_mode, input first_item,
                   input last_item, output ready);
endinterface

// ===== design/crc16_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the running CRC.
interface crc16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] crc_value;
   logic        is_final;

   modport source (output valid, output crc_value, output is_final, input ready);
   modport sink   (input valid, input crc_value, input is_final, output ready);
endinterface

// ===== design/crc16_in_stage.sv =====
// Input register: captures one request item, holds it until the output stage takes it.
module crc16_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   crc16_req_if.sink            req,
   input  logic                 advance,
   output crc16_pkg::stage_type stage
);

   logic                      valid_ff;
   logic                      valid_in;
   crc16_pkg::req_item_type   item_ff;
   logic                      take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;
   assign valid_in  = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_word  <= req.data_word;
         item_ff.byte_mode  <= req.byte_mode;
         item_ff.first_item <= req.first_item;
         item_ff.last_item  <= req.last_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ===== design/crc16_fold.sv =====
// Fold network: restart select plus one or two byte folds into the remainder.
module crc16_fold (
   input  logic [15:0]             remainder,
   input  logic [15:0]             start_value,
   input  crc16_pkg::req_item_type item,
   output logic [15:0]             crc_next
);

   logic [15:0] base;
   logic [15:0] high_folded;

   always_comb begin
      base        = item.first_item ? start_value : remainder;
      high_folded = crc16_pkg::fold_byte(base, item.data_word[15:8]);
      if (item.byte_mode) begin
         crc_next = crc16_pkg::fold_byte(base, item.data_word[7:0]);
      end else begin
         crc_next = crc16_pkg::fold_byte(high_folded, item.data_word[7:0]);
      end
   end

endmodule

// ===== design/crc16_out_stage.sv =====
// Output register and running remainder; presents one result item per folded item.
module crc16_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  crc16_pkg::stage_type stage,
   input  logic [15:0]          crc_next,
   input  logic                 advance,
   output logic                 slot_free,
   output logic [15:0]          remainder,
   crc16_rsp_if.source          rsp
);

   logic                     valid_ff;
   logic                     valid_in;
   logic [15:0]              remainder_ff;
   crc16_pkg::rsp_item_type  result_ff;

   assign slot_free = !valid_ff || rsp.ready;
   assign valid_in  = advance ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         remainder_ff <= crc16_pkg::CRC_RESET_START;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            remainder_ff <= crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff.crc_value <= crc_next;
         result_ff.is_final  <= stage.item.last_item;
      end
   end

   assign remainder     = remainder_ff;
   assign rsp.valid     = valid_ff;
   assign rsp.crc_value = result_ff.crc_value;
   assign rsp.is_final  = result_ff.is_final;

endmodule

// ===== design/crc16_ccitt_stream_top.sv =====
// Top level of the CRC-16/CCITT (poly 0x1021, MSB first) streaming block.
//
// req_chan carries message elements: data_word, byte_mode (1 folds only bits 7..0,
// 0 folds bits 15..8 then 7..0), first_item (restart from start value) and
// last_item. rsp_chan returns one item per request item: crc_value, the
// remainder after that element, and is_final, a copy of last_item.
// csr_write_en/csr_write_data set the start value; it applies from the next item
// that has first_item set.
// A request item passes through an input register, then the fold network into the
// output register, where rsp_chan.valid presents its result. Throughput is one item
// per cycle while rsp_chan.ready stays high, set by the remainder feedback through
// the fold network.
// Reset clears both stages and loads remainder and start value with 0x1021.
// When the receiver stalls, the output register holds its item and the input
// register takes one more; req_chan.ready drops only when both are full.
module crc16_ccitt_stream_top (
   input  logic         clock,
   input  logic         reset,
   crc16_req_if.sink    req_chan,
   crc16_rsp_if.source  rsp_chan,
   input  logic         csr_write_en,
   input  logic [15:0]  csr_write_data
);

   crc16_pkg::stage_type stage;
   logic [15:0]          start_value_ff;
   logic [15:0]          remainder;
   logic [15:0]          crc_next;
   logic                 slot_free;
   logic                 advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= crc16_pkg::CRC_RESET_START;
      end else if (csr_write_en) begin
         start_value_ff <= csr_write_data;
      end
   end

   assign advance = stage.valid && slot_free;

   crc16_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .advance (advance),
      .stage   (stage)
   );

   crc16_fold u_fold (
      .remainder   (remainder),
      .start_value (start_value_ff),
      .item        (stage.item),
      .crc_next    (crc_next)
   );

   crc16_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .crc_next  (crc_next),
      .advance   (advance),
      .slot_free (slot_free),
      .remainder (remainder),
      .rsp       (rsp_chan)
   );

   // a full input stage is only ever refilled while it drains
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && req_chan.ready) |-> advance)
      else $error("input stage refilled while its item is still held");

   // every item moved out of the input stage shows up as a result
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_chan.valid && rsp_chan.crc_value == remainder))
      else $error("advanced item missing from output register");

   // a result taken with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !advance) |=> !rsp_chan.valid)
      else $error("result repeated after it was taken");

   // start value write lands in the register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> (start_value_ff == $past(csr_write_data)))
      else $error("start value write lost");

endmodule
